// ===== rtl/nfwp_pkg.sv =====
// ----------------------------------------------------------------------------
// nfwp_pkg
// Shared types and constants of the next-fit wave planner.
// ----------------------------------------------------------------------------
`default_nettype none

package nfwp_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_MAX_ITEMS   = 3'd0;
  localparam logic [2:0] CFG_BYTE_BUDGET = 3'd1;
  localparam logic [2:0] CFG_BYTES_SPEC  = 3'd2;
  localparam logic [2:0] CFG_OVERHEAD    = 3'd3;
  localparam logic [2:0] CFG_TRANSITIONS = 3'd4;
  localparam logic [2:0] CFG_BYTES_POINT = 3'd5;
  localparam logic [2:0] CFG_DEF_SPECTRA = 3'd6;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QDepth  = 2;

  typedef struct packed {
    logic        start_list;
    logic        skip_item;
    logic        count_present;
    logic [23:0] n_spectra;
  } in_item_t;

  typedef struct packed {
    logic [15:0] item_position;
    logic [15:0] wave_number;
    logic        opened_wave;
    logic [63:0] wave_bytes;
  } out_item_t;

  typedef struct packed {
    logic [15:0] max_items_per_wave;
    logic [63:0] byte_budget;
    logic [31:0] spectrum_bytes;
    logic [31:0] per_item_overhead;
    logic [15:0] transitions_per_item;
    logic [15:0] bytes_per_point;
    logic [23:0] default_spectra;
  } cfg_t;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    logic        start;
    logic        skip;
    logic [15:0] pos;
    logic [23:0] count;
  } qitem_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_SUM,
    BK_DECIDE
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/nfwp_queue.sv =====
// ----------------------------------------------------------------------------
// nfwp_queue
// Two-entry queue that decouples the front and back parts of the planner.
// ----------------------------------------------------------------------------
`default_nettype none

module nfwp_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire nfwp_pkg::qitem_t wr_data_i,
  output logic                 full_o,
  input  wire logic            rd_en_i,
  output nfwp_pkg::qitem_t     rd_data_o,
  output logic                 empty_o
);

  nfwp_pkg::qitem_t mem_q [nfwp_pkg::QDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_wr, do_rd;

  assign full_o    = (cnt_q == 2'(nfwp_pkg::QDepth));
  assign empty_o   = (cnt_q == 2'd0);
  assign do_wr     = wr_en_i & ~full_o;
  assign do_rd     = rd_en_i & ~empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nfwp_front.sv =====
// ----------------------------------------------------------------------------
// nfwp_front
// Accepts items, numbers them by list position and resolves the spectra count.
// ----------------------------------------------------------------------------
`default_nettype none

module nfwp_front #(
  parameter int unsigned MAX_ITEMS = 65536
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire nfwp_pkg::in_item_t in_item_i,
  input  wire nfwp_pkg::cfg_t     cfg_i,
  output logic                   q_wr_o,
  output nfwp_pkg::qitem_t       q_data_o,
  input  wire logic              q_full_i
);

  localparam int unsigned PosW = $clog2(MAX_ITEMS);

  logic [PosW-1:0] pos_q, pos_d, pos_use;
  logic            accept;

  assign full   = q_full_i;
  assign accept = push & ~q_full_i;
  assign q_wr_o = accept;

  always_comb begin
    pos_use = in_item_i.start_list ? '0 : pos_q;
    pos_d   = pos_q;
    if (accept) begin
      pos_d = (pos_use == PosW'(MAX_ITEMS - 1)) ? '0 : pos_use + PosW'(1);
    end
    q_data_o.start = in_item_i.start_list;
    q_data_o.skip  = in_item_i.skip_item;
    q_data_o.pos   = 16'(pos_use);
    q_data_o.count = in_item_i.count_present ? in_item_i.n_spectra
                                             : cfg_i.default_spectra;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nfwp_back.sv =====
// ----------------------------------------------------------------------------
// nfwp_back
// Computes each request's byte cost and places it into a wave by next-fit.
// ----------------------------------------------------------------------------
`default_nettype none

module nfwp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire nfwp_pkg::cfg_t     cfg_i,
  input  wire nfwp_pkg::qitem_t   q_data_i,
  input  wire logic              q_empty_i,
  output logic                   q_rd_o,
  output logic                   empty,
  input  wire logic              pop,
  output nfwp_pkg::out_item_t    out_item_o
);

  nfwp_pkg::back_state_e state_q, state_d;
  nfwp_pkg::qitem_t      cur_q;

  logic [55:0] p_spec_q;
  logic [39:0] p_trn_q;
  logic [56:0] cost_a_q;
  logic [55:0] p_pt_q;
  logic [57:0] cost_q;

  logic [15:0] wave_q, wave_d;
  logic [16:0] items_q, items_d;
  logic [63:0] bytes_q, bytes_d;

  logic                out_vld_q, out_vld_d;
  nfwp_pkg::out_item_t out_q, out_d;

  logic        load, commit, out_free;
  logic [15:0] wave_cur;
  logic [16:0] items_cur, limit;
  logic [63:0] bytes_cur, cost64, sat_sum;
  logic [64:0] raw_sum;
  logic        by_count, by_bytes, opened;

  assign out_free   = ~out_vld_q | pop;
  assign empty      = ~out_vld_q;
  assign out_item_o = out_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nfwp_pkg::BK_IDLE:   if (!q_empty_i) state_d = nfwp_pkg::BK_MUL1;
      nfwp_pkg::BK_MUL1:   state_d = nfwp_pkg::BK_MUL2;
      nfwp_pkg::BK_MUL2:   state_d = nfwp_pkg::BK_SUM;
      nfwp_pkg::BK_SUM:    state_d = nfwp_pkg::BK_DECIDE;
      nfwp_pkg::BK_DECIDE: if (cur_q.skip || out_free) state_d = nfwp_pkg::BK_IDLE;
      default:             state_d = nfwp_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    load   = 1'b0;
    commit = 1'b0;
    unique case (state_q)
      nfwp_pkg::BK_IDLE:   load   = ~q_empty_i;
      nfwp_pkg::BK_DECIDE: commit = cur_q.skip | out_free;
      default: begin
        load   = 1'b0;
        commit = 1'b0;
      end
    endcase
  end

  assign q_rd_o = load;

  // None of the products can reach 2^64, so only the wave total saturates.
  always_comb begin
    wave_cur  = cur_q.start ? 16'd0 : wave_q;
    items_cur = cur_q.start ? 17'd0 : items_q;
    bytes_cur = cur_q.start ? 64'd0 : bytes_q;
    cost64    = 64'(cost_q);
    raw_sum   = {1'b0, bytes_cur} + {1'b0, cost64};
    sat_sum   = raw_sum[64] ? '1 : raw_sum[63:0];
    limit     = (cfg_i.max_items_per_wave == 16'd0) ? 17'd1
                                                    : {1'b0, cfg_i.max_items_per_wave};
    by_count  = items_cur >= limit;
    by_bytes  = (cfg_i.byte_budget != 64'd0) && (items_cur != 17'd0) &&
                (sat_sum > cfg_i.byte_budget);
    opened    = by_count | by_bytes;

    wave_d  = wave_q;
    items_d = items_q;
    bytes_d = bytes_q;
    if (commit) begin
      if (cur_q.skip) begin
        wave_d  = wave_cur;
        items_d = items_cur;
        bytes_d = bytes_cur;
      end else begin
        wave_d  = opened ? wave_cur + 16'd1 : wave_cur;
        items_d = opened ? 17'd1 : items_cur + 17'd1;
        bytes_d = opened ? cost64 : sat_sum;
      end
    end

    out_d.item_position = cur_q.pos;
    out_d.wave_number   = wave_d;
    out_d.opened_wave   = opened;
    out_d.wave_bytes    = bytes_d;

    out_vld_d = out_vld_q;
    if (commit && !cur_q.skip) begin
      out_vld_d = 1'b1;
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nfwp_pkg::BK_IDLE;
      wave_q    <= '0;
      items_q   <= '0;
      bytes_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wave_q    <= wave_d;
      items_q   <= items_d;
      bytes_q   <= bytes_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Cost pipeline: the request is held in cur_q while the stages settle.
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_data_i;
    end
    if (commit && !cur_q.skip) begin
      out_q <= out_d;
    end
    p_spec_q <= 56'(cur_q.count) * 56'(cfg_i.spectrum_bytes);
    p_trn_q  <= 40'(cur_q.count) * 40'(cfg_i.transitions_per_item);
    cost_a_q <= 57'(p_spec_q) + 57'(cfg_i.per_item_overhead);
    p_pt_q   <= 56'(p_trn_q) * 56'(cfg_i.bytes_per_point);
    cost_q   <= 58'(cost_a_q) + 58'(p_pt_q);
  end

endmodule

`default_nettype wire

// ===== rtl/next_fit_wave_planner.sv =====
// ----------------------------------------------------------------------------
// next_fit_wave_planner
// Prices work items in bytes and packs them into waves by next-fit.
// ----------------------------------------------------------------------------
//   Channel   Handshake                  Payload
//   input     push / full                in_item_i  (nfwp_pkg::in_item_t)
//   result    empty / pop                out_item_o (nfwp_pkg::out_item_t)
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Each request passes through the back sequencer's steps in turn (queue read,
// two multiply stages, cost sum, wave decision), and the next request is
// read only once the last is through; the two-entry queue absorbs bursts.
// A result waits in a single output register; an unskipped request stalls
// in the decision step while that register is full and not being popped.
// Reset clears the plan counters and sets the registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module next_fit_wave_planner #(
  parameter int unsigned MAX_ITEMS = 65536
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  output logic                                full,
  input  wire nfwp_pkg::in_item_t              in_item_i,
  output logic                                empty,
  input  wire logic                           pop,
  output nfwp_pkg::out_item_t                 out_item_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [nfwp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [63:0]                    cfg_data_i
);

  nfwp_pkg::cfg_t   cfg_q, cfg_d;
  nfwp_pkg::qitem_t q_wdata, q_rdata;
  logic             q_wr, q_full, q_rd, q_empty;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        nfwp_pkg::CFG_MAX_ITEMS:   cfg_d.max_items_per_wave   = cfg_data_i[15:0];
        nfwp_pkg::CFG_BYTE_BUDGET: cfg_d.byte_budget          = cfg_data_i;
        nfwp_pkg::CFG_BYTES_SPEC:  cfg_d.spectrum_bytes       = cfg_data_i[31:0];
        nfwp_pkg::CFG_OVERHEAD:    cfg_d.per_item_overhead    = cfg_data_i[31:0];
        nfwp_pkg::CFG_TRANSITIONS: cfg_d.transitions_per_item = cfg_data_i[15:0];
        nfwp_pkg::CFG_BYTES_POINT: cfg_d.bytes_per_point      = cfg_data_i[15:0];
        nfwp_pkg::CFG_DEF_SPECTRA: cfg_d.default_spectra      = cfg_data_i[23:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{max_items_per_wave: 16'd1, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  nfwp_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .cfg_i     (cfg_q),
    .q_wr_o    (q_wr),
    .q_data_o  (q_wdata),
    .q_full_i  (q_full)
  );

  nfwp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_wr),
    .wr_data_i (q_wdata),
    .full_o    (q_full),
    .rd_en_i   (q_rd),
    .rd_data_o (q_rdata),
    .empty_o   (q_empty)
  );

  nfwp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_data_i   (q_rdata),
    .q_empty_i  (q_empty),
    .q_rd_o     (q_rd),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
